### rtl/terminal_byte_stream_cursor_engine_macros.svh
// Assertion macros shared by the cursor engine RTL.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef TERMINAL_BYTE_STREAM_CURSOR_ENGINE_MACROS_SVH
`define TERMINAL_BYTE_STREAM_CURSOR_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// property checked every clock outside reset
`define TBSC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tbsc assertion failed");

// condition in one cycle implies a result in the next
`define TBSC_ASSERT_NEXT(label, cond, nxt) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) \
      else $error("tbsc next-cycle assertion failed");

`else

`define TBSC_ASSERT(label, prop)
`define TBSC_ASSERT_NEXT(label, cond, nxt)

`endif

`endif

### rtl/tbsc_pkg.sv
// Shared types, constants and codes of the terminal byte stream cursor engine.
// Depends on nothing; every RTL module of the block refers to it by scoped names.
package tbsc_pkg;

   // screen limits
   localparam int MAX_COLS = 256;
   localparam int MAX_ROWS = 128;

   // field widths
   localparam int COL_W    = 8;
   localparam int ROW_W    = 7;
   localparam int CCOUNT_W = 9;
   localparam int RCOUNT_W = 8;
   localparam int BYTE_W   = 8;
   localparam int COLOR_W  = 32;
   localparam int HEX_W    = 24;
   localparam int CSR_W    = 9;

   localparam logic [CCOUNT_W-1:0] COLS_LIMIT = CCOUNT_W'(MAX_COLS);
   localparam logic [RCOUNT_W-1:0] ROWS_LIMIT = RCOUNT_W'(MAX_ROWS);
   localparam logic [CCOUNT_W-1:0] COLS_RESET = CCOUNT_W'(80);
   localparam logic [RCOUNT_W-1:0] ROWS_RESET = RCOUNT_W'(25);

   // queue depths (powers of two)
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int RES_DEPTH = 4;
   localparam int RES_PTR_W = $clog2(RES_DEPTH);
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
   localparam logic [CMD_CNT_W-1:0] CMD_FULL = CMD_CNT_W'(CMD_DEPTH);
   localparam logic [RES_CNT_W-1:0] RES_FULL = RES_CNT_W'(RES_DEPTH);

   // colors
   localparam logic [COLOR_W-1:0] COLOR_WHITE  = 32'hFFFF_FFFF;
   localparam logic [COLOR_W-1:0] COLOR_ERASE  = 32'h00FF_FFFF;
   localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;

   // character codes
   localparam logic [BYTE_W-1:0] CHAR_NUL      = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_BS       = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_LF       = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_ESC      = 8'h1B;
   localparam logic [BYTE_W-1:0] CHAR_SPACE    = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_HASH     = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_ZERO     = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_M        = 8'h6D;

   // configuration register indexes
   localparam logic CSR_COLUMN_COUNT = 1'b0;
   localparam logic CSR_ROW_COUNT    = 1'b1;

   // request opcodes
   localparam logic OP_TEXT  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      ACT_DRAW   = 2'd0,
      ACT_SCROLL = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_ESC     = 3'd1,
      PH_BRACKET = 3'd2,
      PH_ZERO    = 3'd3,
      PH_HEX     = 3'd4,
      PH_WAIT_M  = 3'd5
   } phase_type;

   // classified word passed from front to back: a clear or up to two text bytes
   typedef struct packed {
      logic                is_clear;
      logic                b0_valid;
      logic                b1_valid;
      logic [BYTE_W-1:0]   b0;
      logic [BYTE_W-1:0]   b1;
      logic [COLOR_W-1:0]  color;
   } cmd_type;

   // one result word
   typedef struct packed {
      action_type          action;
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic [BYTE_W-1:0]   glyph;
      logic [COLOR_W-1:0]  color;
      logic                last;
   } res_type;

endpackage

### rtl/tbsc_front.sv
// Front end: escape parser and color state; turns each accepted word into a command.
// Depends on tbsc_pkg.
module tbsc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         opcode,
   input  logic [tbsc_pkg::BYTE_W-1:0]  data_byte,
   input  logic                         end_of_message,
   output logic                         cmd_push,
   output tbsc_pkg::cmd_type            cmd_word
);

   tbsc_pkg::phase_type                 phase_ff, phase_in, phase_feed;
   logic [tbsc_pkg::COLOR_W-1:0]        color_ff, color_in, color_feed;
   logic [tbsc_pkg::HEX_W-1:0]          acc_ff, acc_in, acc_feed;
   logic [2:0]                          cnt_ff, cnt_in, cnt_feed;
   logic                                text_go;
   logic                                is_hex;
   logic [3:0]                          nib_value;
   logic                                take_plain;
   logic                                zero_first;
   logic                                plain_ok;
   logic [2:0]                          cnt_inc;

   // left-justify the collected digits, force alpha
   function automatic logic [tbsc_pkg::COLOR_W-1:0] apply_hex(
      input logic [tbsc_pkg::HEX_W-1:0] acc,
      input logic [2:0]                 n
   );
      logic [tbsc_pkg::HEX_W-1:0] v;
      case (n)
         3'd0:    v = 24'h00_0000;
         3'd1:    v = {acc[3:0], 20'h0_0000};
         3'd2:    v = {acc[7:0], 16'h0000};
         3'd3:    v = {acc[11:0], 12'h000};
         3'd4:    v = {acc[15:0], 8'h00};
         3'd5:    v = {acc[19:0], 4'h0};
         default: v = acc;
      endcase
      return tbsc_pkg::ALPHA_OPAQUE | {8'h00, v};
   endfunction

   // an escape byte in text position arms the parser
   function automatic tbsc_pkg::phase_type plain_phase(input logic [tbsc_pkg::BYTE_W-1:0] b);
      return (b == tbsc_pkg::CHAR_ESC) ? tbsc_pkg::PH_ESC : tbsc_pkg::PH_IDLE;
   endfunction

   assign text_go = accept && (opcode == tbsc_pkg::OP_TEXT);
   assign cnt_inc = cnt_ff + 3'd1;

   // hex digit decode
   always_comb begin
      is_hex    = 1'b0;
      nib_value = 4'h0;
      if (data_byte inside {[8'h30:8'h39]}) begin
         is_hex    = 1'b1;
         nib_value = data_byte[3:0];
      end else if (data_byte inside {[8'h61:8'h66]}) begin
         is_hex    = 1'b1;
         nib_value = 4'(data_byte - 8'h57);
      end else if (data_byte inside {[8'h41:8'h46]}) begin
         is_hex    = 1'b1;
         nib_value = 4'(data_byte - 8'h37);
      end
   end

   // parser next state
   always_comb begin
      phase_feed = phase_ff;
      if (text_go) begin
         case (phase_ff)
            tbsc_pkg::PH_ESC: begin
               phase_feed = (data_byte == tbsc_pkg::CHAR_LBRACKET) ?
                            tbsc_pkg::PH_BRACKET : plain_phase(data_byte);
            end
            tbsc_pkg::PH_BRACKET: begin
               if (data_byte == tbsc_pkg::CHAR_ZERO)
                  phase_feed = tbsc_pkg::PH_ZERO;
               else if (data_byte == tbsc_pkg::CHAR_HASH)
                  phase_feed = tbsc_pkg::PH_HEX;
               else if (data_byte == tbsc_pkg::CHAR_M)
                  phase_feed = tbsc_pkg::PH_IDLE;
               else
                  phase_feed = plain_phase(data_byte);
            end
            tbsc_pkg::PH_ZERO: begin
               if (data_byte == tbsc_pkg::CHAR_M || data_byte == tbsc_pkg::CHAR_NUL)
                  phase_feed = tbsc_pkg::PH_IDLE;
               else
                  phase_feed = plain_phase(data_byte);
            end
            tbsc_pkg::PH_HEX: begin
               if (is_hex)
                  phase_feed = (cnt_inc >= 3'd6) ? tbsc_pkg::PH_WAIT_M : tbsc_pkg::PH_HEX;
               else if (data_byte == tbsc_pkg::CHAR_M)
                  phase_feed = tbsc_pkg::PH_IDLE;
               else
                  phase_feed = plain_phase(data_byte);
            end
            tbsc_pkg::PH_WAIT_M: begin
               phase_feed = (data_byte == tbsc_pkg::CHAR_M) ?
                            tbsc_pkg::PH_IDLE : plain_phase(data_byte);
            end
            default: phase_feed = plain_phase(data_byte);
         endcase
      end
      phase_in = (text_go && end_of_message) ? tbsc_pkg::PH_IDLE : phase_feed;
   end

   // parser outputs: color, hex run and the command word
   always_comb begin
      color_feed = color_ff;
      acc_feed   = acc_ff;
      cnt_feed   = cnt_ff;
      take_plain = 1'b0;
      zero_first = 1'b0;
      case (phase_ff)
         tbsc_pkg::PH_ESC: take_plain = (data_byte != tbsc_pkg::CHAR_LBRACKET);
         tbsc_pkg::PH_BRACKET: begin
            if (data_byte == tbsc_pkg::CHAR_HASH) begin
               acc_feed = '0;
               cnt_feed = '0;
            end
            take_plain = !(data_byte == tbsc_pkg::CHAR_ZERO ||
                           data_byte == tbsc_pkg::CHAR_HASH ||
                           data_byte == tbsc_pkg::CHAR_M);
         end
         tbsc_pkg::PH_ZERO: begin
            if (data_byte == tbsc_pkg::CHAR_M || data_byte == tbsc_pkg::CHAR_NUL) begin
               color_feed = tbsc_pkg::COLOR_WHITE;
            end else begin
               zero_first = 1'b1;
               take_plain = 1'b1;
            end
         end
         tbsc_pkg::PH_HEX: begin
            if (is_hex) begin
               acc_feed = {acc_ff[tbsc_pkg::HEX_W-5:0], nib_value};
               cnt_feed = cnt_inc;
               if (cnt_inc >= 3'd6)
                  color_feed = apply_hex({acc_ff[tbsc_pkg::HEX_W-5:0], nib_value}, cnt_inc);
            end else begin
               color_feed = apply_hex(acc_ff, cnt_ff);
               take_plain = (data_byte != tbsc_pkg::CHAR_M);
            end
         end
         tbsc_pkg::PH_WAIT_M: take_plain = (data_byte != tbsc_pkg::CHAR_M);
         default: take_plain = 1'b1;
      endcase

      plain_ok = take_plain && (data_byte != tbsc_pkg::CHAR_ESC);

      cmd_word.is_clear = (opcode == tbsc_pkg::OP_CLEAR);
      cmd_word.color    = color_feed;
      if (zero_first) begin
         cmd_word.b0       = tbsc_pkg::CHAR_ZERO;
         cmd_word.b0_valid = 1'b1;
         cmd_word.b1       = data_byte;
         cmd_word.b1_valid = plain_ok;
      end else begin
         cmd_word.b0       = data_byte;
         cmd_word.b0_valid = plain_ok;
         cmd_word.b1       = data_byte;
         cmd_word.b1_valid = 1'b0;
      end
      // every word goes back, escape-only ones still saturate the cursor
      cmd_push = accept;

      // end of message closes any pending escape
      color_in = color_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      if (text_go) begin
         color_in = color_feed;
         acc_in   = acc_feed;
         cnt_in   = cnt_feed;
         if (end_of_message) begin
            if (phase_feed == tbsc_pkg::PH_HEX)
               color_in = apply_hex(acc_feed, cnt_feed);
            else if (phase_feed == tbsc_pkg::PH_ZERO)
               color_in = tbsc_pkg::COLOR_WHITE;
            acc_in = '0;
            cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tbsc_pkg::PH_IDLE;
         color_ff <= tbsc_pkg::COLOR_WHITE;
         acc_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         color_ff <= color_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### rtl/tbsc_cmd_queue.sv
// Command queue between the front end and the back end.
// Depends on tbsc_pkg.
module tbsc_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tbsc_pkg::cmd_type   push_word,
   output logic                full,
   input  logic                pop,
   output tbsc_pkg::cmd_type   head_word,
   output logic                head_valid
);

   tbsc_pkg::cmd_type                   mem_ff [tbsc_pkg::CMD_DEPTH];
   logic [tbsc_pkg::CMD_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tbsc_pkg::CMD_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tbsc_pkg::CMD_CNT_W-1:0]      count_ff, count_in;
   logic                                do_push, do_pop;

   assign full       = (count_ff == tbsc_pkg::CMD_FULL);
   assign head_valid = (count_ff != '0);
   assign head_word  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + tbsc_pkg::CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + tbsc_pkg::CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + tbsc_pkg::CMD_CNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - tbsc_pkg::CMD_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_word;
   end

endmodule

### rtl/tbsc_back.sv
// Back end: cursor engine that steps through commands and queues result words.
// Depends on tbsc_pkg and terminal_byte_stream_cursor_engine_macros.svh.
`include "terminal_byte_stream_cursor_engine_macros.svh"

module tbsc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [tbsc_pkg::CCOUNT_W-1:0]  column_count,
   input  logic [tbsc_pkg::RCOUNT_W-1:0]  row_count,
   input  tbsc_pkg::cmd_type              head,
   input  logic                           head_valid,
   output logic                           head_pop,
   input  logic                           pop,
   output logic                           empty,
   output tbsc_pkg::res_type              rsp_word
);

   logic [tbsc_pkg::COL_W-1:0]      col_ff, col_c, ncol;
   logic [tbsc_pkg::ROW_W-1:0]      row_ff, row_c, nrow;
   logic                            scroll_pend_ff, scroll_pend_in;
   logic                            sel_ff, sel_in;
   logic [tbsc_pkg::CCOUNT_W-1:0]   eff_cols;
   logic [tbsc_pkg::RCOUNT_W-1:0]   eff_rows;
   logic                            col_end, row_end;
   logic [tbsc_pkg::BYTE_W-1:0]     cur_byte;
   logic                            step_go;
   logic                            emit;
   logic                            second;
   logic                            done;
   tbsc_pkg::res_type               res_word;

   tbsc_pkg::res_type               res_mem_ff [tbsc_pkg::RES_DEPTH];
   logic [tbsc_pkg::RES_PTR_W-1:0]  res_wr_ff, res_wr_in;
   logic [tbsc_pkg::RES_PTR_W-1:0]  res_rd_ff, res_rd_in;
   logic [tbsc_pkg::RES_CNT_W-1:0]  res_count_ff, res_count_in;
   logic                            res_full, res_push, res_pop;

   // does a text byte at this cursor produce any result word
   function automatic logic has_result(
      input logic [tbsc_pkg::BYTE_W-1:0]   b,
      input logic [tbsc_pkg::COL_W-1:0]    col,
      input logic [tbsc_pkg::ROW_W-1:0]    row,
      input logic [tbsc_pkg::RCOUNT_W-1:0] rows
   );
      logic r;
      case (b)
         tbsc_pkg::CHAR_LF: r = (({1'b0, row} + 8'd1) >= rows);
         tbsc_pkg::CHAR_BS: r = (col != '0) || (row != '0);
         default:           r = 1'b1;
      endcase
      return r;
   endfunction

   // effective screen size
   always_comb begin
      if (column_count == '0)
         eff_cols = tbsc_pkg::CCOUNT_W'(1);
      else if (column_count > tbsc_pkg::COLS_LIMIT)
         eff_cols = tbsc_pkg::COLS_LIMIT;
      else
         eff_cols = column_count;
      if (row_count == '0)
         eff_rows = tbsc_pkg::RCOUNT_W'(1);
      else if (row_count > tbsc_pkg::ROWS_LIMIT)
         eff_rows = tbsc_pkg::ROWS_LIMIT;
      else
         eff_rows = row_count;
   end

   // cursor saturated to the screen, wrap tests
   always_comb begin
      col_c   = ({1'b0, col_ff} >= eff_cols) ? tbsc_pkg::COL_W'(eff_cols - 9'd1) : col_ff;
      row_c   = ({1'b0, row_ff} >= eff_rows) ? tbsc_pkg::ROW_W'(eff_rows - 8'd1) : row_ff;
      col_end = (({1'b0, col_c} + 9'd1) >= eff_cols);
      row_end = (({1'b0, row_c} + 8'd1) >= eff_rows);
   end

   assign res_full = (res_count_ff == tbsc_pkg::RES_FULL);
   assign step_go  = head_valid && !res_full;
   assign cur_byte = sel_ff ? head.b1 : head.b0;

   // one step of the cursor engine: at most one result word
   always_comb begin
      emit           = 1'b0;
      res_word       = '0;
      res_word.action = tbsc_pkg::ACT_DRAW;
      ncol           = col_c;
      nrow           = row_c;
      scroll_pend_in = 1'b0;
      if (scroll_pend_ff) begin
         emit            = 1'b1;
         res_word.action = tbsc_pkg::ACT_SCROLL;
      end else if (head.is_clear) begin
         emit            = 1'b1;
         res_word.action = tbsc_pkg::ACT_CLEAR;
         ncol            = '0;
         nrow            = '0;
      end else if (!head.b0_valid) begin
         // escape-only word: nothing drawn, cursor only saturated
         emit = 1'b0;
      end else begin
         case (cur_byte)
            tbsc_pkg::CHAR_LF: begin
               ncol = '0;
               if (row_end) begin
                  emit            = 1'b1;
                  res_word.action = tbsc_pkg::ACT_SCROLL;
               end else begin
                  nrow = row_c + 7'd1;
               end
            end
            tbsc_pkg::CHAR_BS: begin
               if (col_c == '0) begin
                  if (row_c != '0) begin
                     nrow = row_c - 7'd1;
                     ncol = tbsc_pkg::COL_W'(eff_cols - 9'd1);
                     emit = 1'b1;
                  end
               end else begin
                  ncol = col_c - 8'd1;
                  emit = 1'b1;
               end
               res_word.col   = ncol;
               res_word.row   = nrow;
               res_word.glyph = tbsc_pkg::CHAR_SPACE;
               res_word.color = tbsc_pkg::COLOR_ERASE;
            end
            default: begin
               emit           = 1'b1;
               res_word.col   = col_c;
               res_word.row   = row_c;
               res_word.glyph = cur_byte;
               res_word.color = head.color;
               if (col_end) begin
                  ncol = '0;
                  if (row_end)
                     scroll_pend_in = 1'b1;
                  else
                     nrow = row_c + 7'd1;
               end else begin
                  ncol = col_c + 8'd1;
               end
            end
         endcase
      end

      // what follows this step within the same command
      second = !scroll_pend_in && !sel_ff && head.b1_valid && !head.is_clear;
      done   = !scroll_pend_in && !second;
      sel_in = second ? 1'b1 : (done ? 1'b0 : sel_ff);
      res_word.last = !scroll_pend_in &&
                      !(second && has_result(head.b1, ncol, nrow, eff_rows));
   end

   assign head_pop = step_go && done;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         scroll_pend_ff <= 1'b0;
         sel_ff         <= 1'b0;
      end else if (step_go) begin
         col_ff         <= ncol;
         row_ff         <= nrow;
         scroll_pend_ff <= scroll_pend_in;
         sel_ff         <= sel_in;
      end
   end

   // result queue toward the rsp side
   assign res_push = step_go && emit;
   assign empty    = (res_count_ff == '0);
   assign res_pop  = pop && !empty;
   assign rsp_word = res_mem_ff[res_rd_ff];

   always_comb begin
      res_wr_in    = res_push ? res_wr_ff + tbsc_pkg::RES_PTR_W'(1) : res_wr_ff;
      res_rd_in    = res_pop  ? res_rd_ff + tbsc_pkg::RES_PTR_W'(1) : res_rd_ff;
      res_count_in = res_count_ff;
      if (res_push && !res_pop)
         res_count_in = res_count_ff + tbsc_pkg::RES_CNT_W'(1);
      else if (res_pop && !res_push)
         res_count_in = res_count_ff - tbsc_pkg::RES_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff    <= '0;
         res_rd_ff    <= '0;
         res_count_ff <= '0;
      end else begin
         res_wr_ff    <= res_wr_in;
         res_rd_ff    <= res_rd_in;
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push)
         res_mem_ff[res_wr_ff] <= res_word;
   end

   // checks
   `TBSC_ASSERT(a_res_count_bound, res_count_ff <= tbsc_pkg::RES_FULL)
   `TBSC_ASSERT(a_scroll_holds_cmd, scroll_pend_ff |-> head_valid)
   `TBSC_ASSERT(a_sel_second_byte, sel_ff |-> (head_valid && head.b1_valid))
   `TBSC_ASSERT_NEXT(a_clear_homes, step_go && head.is_clear, {col_ff, row_ff} == '0)

endmodule

### rtl/terminal_byte_stream_cursor_engine.sv
// Top level of the terminal byte stream cursor engine: CSRs and front/queue/back wiring.
// Depends on tbsc_pkg, tbsc_front, tbsc_cmd_queue and tbsc_back.
//
//   channel   handshake          payload
//   req       push / full        req_opcode, req_data_byte, req_end_of_message
//   rsp       pop / empty        rsp_action, rsp_cell_col, rsp_cell_row,
//                                rsp_glyph_code, rsp_cell_color, rsp_last_result
//   csr       csr_write_enable   csr_index, csr_write_data
//
// The front accepts one word per cycle, while the command queue is not full, into a four-entry command queue.
// The back retires one step per cycle: one step for most words, escape words that
// draw nothing included, two when a draw wraps into a scroll, up to four for ESC[0
// followed by a text byte. Results wait in a four-entry queue.
// full rises while the command queue holds four commands; the back stalls while
// the result queue is full. Synchronous reset: cursor home, color opaque white,
// parser idle, queues empty, screen 80 by 25.
module terminal_byte_stream_cursor_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_opcode,
   input  logic [tbsc_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                            req_end_of_message,
   output logic                            empty,
   input  logic                            pop,
   output logic [1:0]                      rsp_action,
   output logic [tbsc_pkg::COL_W-1:0]      rsp_cell_col,
   output logic [tbsc_pkg::ROW_W-1:0]      rsp_cell_row,
   output logic [tbsc_pkg::BYTE_W-1:0]     rsp_glyph_code,
   output logic [tbsc_pkg::COLOR_W-1:0]    rsp_cell_color,
   output logic                            rsp_last_result,
   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [tbsc_pkg::CSR_W-1:0]      csr_write_data
);

   logic [tbsc_pkg::CCOUNT_W-1:0]  column_count_ff, column_count_in;
   logic [tbsc_pkg::RCOUNT_W-1:0]  row_count_ff, row_count_in;
   logic                           accept;
   logic                           cmd_push;
   tbsc_pkg::cmd_type              cmd_word;
   tbsc_pkg::cmd_type              head_word;
   logic                           head_valid;
   logic                           head_pop;
   tbsc_pkg::res_type              rsp_word;

   // configuration registers
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tbsc_pkg::CSR_COLUMN_COUNT: column_count_in = csr_write_data;
            tbsc_pkg::CSR_ROW_COUNT:    row_count_in    = csr_write_data[tbsc_pkg::RCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= tbsc_pkg::COLS_RESET;
         row_count_ff    <= tbsc_pkg::ROWS_RESET;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   assign accept = push && !full;

   tbsc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .opcode         (req_opcode),
      .data_byte      (req_data_byte),
      .end_of_message (req_end_of_message),
      .cmd_push       (cmd_push),
      .cmd_word       (cmd_word)
   );

   tbsc_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_word  (cmd_word),
      .full       (full),
      .pop        (head_pop),
      .head_word  (head_word),
      .head_valid (head_valid)
   );

   tbsc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .column_count (column_count_ff),
      .row_count    (row_count_ff),
      .head         (head_word),
      .head_valid   (head_valid),
      .head_pop     (head_pop),
      .pop          (pop),
      .empty        (empty),
      .rsp_word     (rsp_word)
   );

   // result word onto the rsp ports
   assign rsp_action      = rsp_word.action;
   assign rsp_cell_col    = rsp_word.col;
   assign rsp_cell_row    = rsp_word.row;
   assign rsp_glyph_code  = rsp_word.glyph;
   assign rsp_cell_color  = rsp_word.color;
   assign rsp_last_result = rsp_word.last;

endmodule
